[hdl/bnms_pkg.sv]
// Shared constants, command and status structs, and the overlap penalty function.
package bnms_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int FIELD_W = 16;
    localparam int KEPT_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_RW = 37;
    localparam int DIV_QW = 17;
    localparam int DIV_SW = 5;
    localparam int PEN_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_IOU_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd2;

    localparam logic [FIELD_W-1:0] IOU_THR_RESET = 16'd29491;

    typedef struct packed {
        logic load_we;
        logic alive_we;
        logic alive_wdata;
        logic latch_si;
        logic rank_clr;
        logic rank_upd;
        logic j_lt_i;
        logic ord_we;
        logic latch_p;
        logic start_ov;
    } t_dp_cmd;

    typedef struct packed {
        logic alive;
        logic score_ok;
        logic ov_done;
        logic ov_hit;
    } t_dp_stat;

    // Largest P with P^5 * 255^3 <= k^3 * 2^80, i.e. 65536 * (k/255)^0.6 rounded down.
    function automatic logic [PEN_W-1:0] pen_value(input int k);
        logic [127:0] kk;
        logic [127:0] lim;
        logic [127:0] m;
        logic [127:0] p5;
        logic [17:0]  lo;
        logic [17:0]  hi;
        logic [17:0]  mid;
        kk  = 128'(k);
        lim = (kk * kk * kk) << 80;
        lo  = 18'd0;
        hi  = 18'd65536;
        for (int it = 0; it < 18; it++) begin
            if (lo < hi) begin
                mid = (lo + hi + 18'd1) >> 1;
                m   = 128'(mid);
                p5  = m * m * m * m * m * 128'd16581375;
                if (p5 <= lim) begin
                    lo = mid;
                end else begin
                    hi = mid - 18'd1;
                end
            end
        end
        return lo[PEN_W-1:0];
    endfunction

endpackage

[hdl/bnms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bnms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/bnms_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the IoU and penalty-index divisions.
module bnms_div import bnms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_RW-1:0] i_dividend,
    input  logic [DIV_QW-1:0] i_bits,
    input  logic [DIV_RW-1:0] i_divisor,
    input  logic [DIV_SW-1:0] i_steps,
    output logic              o_done,
    output logic [DIV_QW-1:0] o_quotient
);
    logic              r_busy;
    logic              r_done;
    logic [DIV_SW-1:0] r_cnt;
    logic [DIV_RW-1:0] r_rem;
    logic [DIV_QW-1:0] r_bits;
    logic [DIV_QW-1:0] r_quo;
    logic [DIV_RW-1:0] r_div;
    logic [DIV_RW:0]   trial;
    logic [DIV_RW:0]   diff;
    logic              ge;

    // The incoming remainder is always below the divisor, so the shifted value fits.
    assign trial = {r_rem, r_bits[DIV_QW-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_SW'(1);
                if (r_cnt == DIV_SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_bits <= i_bits;
            r_div  <= i_divisor;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
            r_quo  <= {r_quo[DIV_QW-2:0], ge};
            r_bits <= {r_bits[DIV_QW-2:0], 1'b0};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

[hdl/bnms_datapath.sv]
// Box memories, rank counter, configuration registers and the multi-cycle overlap unit.
module bnms_datapath import bnms_pkg::*; #(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    input  logic [$clog2(MAX_BOXES)-1:0] i_wr_addr,
    input  logic [$clog2(MAX_BOXES)-1:0] i_rd_addr,
    input  logic [$clog2(MAX_BOXES)-1:0] i_ord_raddr,
    input  logic [$clog2(MAX_BOXES)-1:0] i_ord_wdata,
    input  logic [FIELD_W-1:0]           i_center_x,
    input  logic [FIELD_W-1:0]           i_center_y,
    input  logic [FIELD_W-1:0]           i_box_width,
    input  logic [FIELD_W-1:0]           i_box_height,
    input  logic [FIELD_W-1:0]           i_box_score,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [FIELD_W-1:0]           i_cfg_data,
    output t_dp_stat                     o_stat,
    output logic [$clog2(MAX_BOXES)-1:0] o_ord_rdata
);
    localparam int IW = $clog2(MAX_BOXES);

    localparam logic [2:0] OV_IDLE = 3'd0;
    localparam logic [2:0] OV_GEO  = 3'd1;
    localparam logic [2:0] OV_MUL  = 3'd2;
    localparam logic [2:0] OV_SUM  = 3'd3;
    localparam logic [2:0] OV_D1S  = 3'd4;
    localparam logic [2:0] OV_D1W  = 3'd5;
    localparam logic [2:0] OV_D2S  = 3'd6;
    localparam logic [2:0] OV_D2W  = 3'd7;

    logic [FIELD_W-1:0] r_iou_thr;
    logic [FIELD_W-1:0] r_score_thr;
    logic               r_mode;

    logic [4*FIELD_W-1:0] box_rdata;
    logic [FIELD_W-1:0]   score_rdata;
    logic                 alive_rdata;

    logic [FIELD_W-1:0] r_si;
    logic [IW-1:0]      r_rank;

    logic [FIELD_W-1:0] r_px, r_py, r_pw, r_ph;
    logic [FIELD_W-1:0] r_qx, r_qy, r_qw, r_qh;

    logic [2:0]  r_ovs;
    logic [2:0]  n_ovs;
    logic        r_fin;
    logic        r_neg;
    logic [16:0] r_ow, r_oh;
    logic [17:0] r_ew, r_eh;
    logic [15:0] r_dx, r_dy;
    logic [33:0] r_inter;
    logic [31:0] r_a1, r_a2, r_dx2, r_dy2;
    logic [35:0] r_ew2, r_eh2;
    logic [34:0] r_uni;
    logic [36:0] r_e;
    logic [42:0] r_num;
    logic [PEN_W-1:0] r_iou;
    logic [PEN_W-1:0] r_pen;

    logic signed [18:0] l1, r1, t1, d1, l2, r2, t2, d2;
    logic signed [19:0] ow_s, oh_s, ew_s, eh_s;
    logic [32:0]        dsq;
    logic signed [18:0] ov_val;

    logic              div_start;
    logic [DIV_RW-1:0] div_dividend;
    logic [DIV_QW-1:0] div_bits;
    logic [DIV_RW-1:0] div_divisor;
    logic [DIV_SW-1:0] div_steps;
    logic              div_done;
    logic [DIV_QW-1:0] div_quo;

    logic [PEN_W-1:0] pen_rom [256];

    for (genvar gk = 0; gk < 256; gk++) begin : g_pen
        localparam logic [PEN_W-1:0] PV = pen_value(gk);
        assign pen_rom[gk] = PV;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_thr   <= IOU_THR_RESET;
            r_score_thr <= '0;
            r_mode      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IOU_THR:   r_iou_thr   <= i_cfg_data;
                CFG_SCORE_THR: r_score_thr <= i_cfg_data;
                CFG_MODE:      r_mode      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    bnms_ram #(.WIDTH(4 * FIELD_W), .DEPTH(MAX_BOXES)) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (i_wr_addr),
        .i_wdata ({i_box_height, i_box_width, i_center_y, i_center_x}),
        .i_raddr (i_rd_addr),
        .o_rdata (box_rdata)
    );

    bnms_ram #(.WIDTH(FIELD_W), .DEPTH(MAX_BOXES)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (i_wr_addr),
        .i_wdata (i_box_score),
        .i_raddr (i_rd_addr),
        .o_rdata (score_rdata)
    );

    bnms_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_alive_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alive_we),
        .i_waddr (i_wr_addr),
        .i_wdata (i_cmd.alive_wdata),
        .i_raddr (i_rd_addr),
        .o_rdata (alive_rdata)
    );

    bnms_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ord_we),
        .i_waddr (r_rank),
        .i_wdata (i_ord_wdata),
        .i_raddr (i_ord_raddr),
        .o_rdata (o_ord_rdata)
    );

    // Stable descending rank: count boxes with a higher score, or an equal score and lower index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_si) begin
            r_si <= score_rdata;
        end
        if (i_cmd.rank_clr) begin
            r_rank <= '0;
        end else if (i_cmd.rank_upd) begin
            if (score_rdata > r_si || (score_rdata == r_si && i_cmd.j_lt_i)) begin
                r_rank <= r_rank + IW'(1);
            end
        end
        if (i_cmd.latch_p) begin
            {r_ph, r_pw, r_py, r_px} <= box_rdata;
        end
        if (i_cmd.start_ov) begin
            {r_qh, r_qw, r_qy, r_qx} <= box_rdata;
        end
    end

    // Box edges are kept doubled so that they stay integers.
    always_comb begin
        l1 = $signed({2'b0, r_px, 1'b0}) - $signed({3'b0, r_pw});
        r1 = $signed({2'b0, r_px, 1'b0}) + $signed({3'b0, r_pw});
        t1 = $signed({2'b0, r_py, 1'b0}) - $signed({3'b0, r_ph});
        d1 = $signed({2'b0, r_py, 1'b0}) + $signed({3'b0, r_ph});
        l2 = $signed({2'b0, r_qx, 1'b0}) - $signed({3'b0, r_qw});
        r2 = $signed({2'b0, r_qx, 1'b0}) + $signed({3'b0, r_qw});
        t2 = $signed({2'b0, r_qy, 1'b0}) - $signed({3'b0, r_qh});
        d2 = $signed({2'b0, r_qy, 1'b0}) + $signed({3'b0, r_qh});
        ow_s = 20'((r1 < r2) ? r1 : r2) - 20'((l1 > l2) ? l1 : l2);
        oh_s = 20'((d1 < d2) ? d1 : d2) - 20'((t1 > t2) ? t1 : t2);
        ew_s = 20'((r1 > r2) ? r1 : r2) - 20'((l1 < l2) ? l1 : l2);
        eh_s = 20'((d1 > d2) ? d1 : d2) - 20'((t1 < t2) ? t1 : t2);
    end

    assign dsq = 33'(r_dx2) + 33'(r_dy2);

    always_comb begin
        n_ovs        = r_ovs;
        div_start    = 1'b0;
        div_dividend = 37'(r_inter[33:1]);
        div_bits     = {r_inter[0], 16'b0};
        div_divisor  = 37'(r_uni);
        div_steps    = DIV_SW'(17);
        case (r_ovs)
            OV_IDLE: if (i_cmd.start_ov) n_ovs = OV_GEO;
            OV_GEO:  n_ovs = OV_MUL;
            OV_MUL:  n_ovs = OV_SUM;
            OV_SUM:  n_ovs = OV_D1S;
            OV_D1S: begin
                if (r_neg) begin
                    n_ovs = OV_IDLE;
                end else if (r_uni == '0) begin
                    n_ovs = OV_D2S;
                end else begin
                    div_start = 1'b1;
                    n_ovs     = OV_D1W;
                end
            end
            OV_D1W: if (div_done) n_ovs = OV_D2S;
            OV_D2S: begin
                div_dividend = 37'(r_num[42:8]);
                div_bits     = {r_num[7:0], 9'b0};
                div_divisor  = r_e;
                div_steps    = DIV_SW'(8);
                if (!r_mode || r_e == '0) begin
                    n_ovs = OV_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_ovs     = OV_D2W;
                end
            end
            OV_D2W: if (div_done) n_ovs = OV_IDLE;
            default: n_ovs = OV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovs <= OV_IDLE;
            r_fin <= 1'b0;
        end else begin
            r_ovs <= n_ovs;
            r_fin <= (r_ovs != OV_IDLE) && (n_ovs == OV_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_ovs)
            OV_GEO: begin
                r_neg <= ow_s[19] | oh_s[19];
                r_ow  <= ow_s[16:0];
                r_oh  <= oh_s[16:0];
                r_ew  <= ew_s[17:0];
                r_eh  <= eh_s[17:0];
                r_dx  <= (r_px > r_qx) ? r_px - r_qx : r_qx - r_px;
                r_dy  <= (r_py > r_qy) ? r_py - r_qy : r_qy - r_py;
                r_iou <= '0;
                r_pen <= '0;
            end
            OV_MUL: begin
                r_inter <= r_ow * r_oh;
                r_a1    <= r_pw * r_ph;
                r_a2    <= r_qw * r_qh;
                r_ew2   <= r_ew * r_ew;
                r_eh2   <= r_eh * r_eh;
                r_dx2   <= r_dx * r_dx;
                r_dy2   <= r_dy * r_dy;
            end
            OV_SUM: begin
                r_uni <= 35'({r_a1, 2'b0}) + 35'({r_a2, 2'b0}) - 35'(r_inter);
                r_e   <= 37'(r_ew2) + 37'(r_eh2);
                r_num <= 43'({dsq, 10'b0}) - 43'({dsq, 2'b0});
            end
            OV_D1W: if (div_done) r_iou <= div_quo;
            OV_D2W: if (div_done) r_pen <= pen_rom[div_quo[7:0]];
            default: begin
            end
        endcase
    end

    bnms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_bits     (div_bits),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign ov_val = $signed({2'b0, r_iou}) - $signed({2'b0, r_pen});

    assign o_stat.alive    = alive_rdata;
    assign o_stat.score_ok = score_rdata >= r_score_thr;
    assign o_stat.ov_done  = r_fin;
    assign o_stat.ov_hit   = ov_val >= $signed({3'b0, r_iou_thr});
endmodule

[hdl/bnms_ctrl.sv]
// Sequencer for loading, ranking and greedy suppression, plus the result output register.
module bnms_ctrl import bnms_pkg::*; #(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_last_box,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [KEPT_W-1:0]            o_kept_index,
    output logic                         o_valid_res,
    output logic                         o_overflow,
    output logic                         o_last,
    output t_dp_cmd                      o_cmd,
    output logic [$clog2(MAX_BOXES)-1:0] o_wr_addr,
    output logic [$clog2(MAX_BOXES)-1:0] o_rd_addr,
    output logic [$clog2(MAX_BOXES)-1:0] o_ord_raddr,
    output logic [$clog2(MAX_BOXES)-1:0] o_ord_wdata,
    input  t_dp_stat                     i_stat,
    input  logic [$clog2(MAX_BOXES)-1:0] i_ord_rdata
);
    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RDI   = 4'd1;
    localparam logic [3:0] ST_LATI  = 4'd2;
    localparam logic [3:0] ST_RDJ   = 4'd3;
    localparam logic [3:0] ST_CMPJ  = 4'd4;
    localparam logic [3:0] ST_WRO   = 4'd5;
    localparam logic [3:0] ST_RDA   = 4'd6;
    localparam logic [3:0] ST_WTA   = 4'd7;
    localparam logic [3:0] ST_CHKP  = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;
    localparam logic [3:0] ST_RDB   = 4'd10;
    localparam logic [3:0] ST_WTB   = 4'd11;
    localparam logic [3:0] ST_CHKQ  = 4'd12;
    localparam logic [3:0] ST_OV    = 4'd13;
    localparam logic [3:0] ST_FIN   = 4'd14;

    logic [3:0]  r_state;
    logic [3:0]  n_state;
    logic [CW-1:0] r_cnt, r_i, r_j, r_a, r_b;
    logic [IW-1:0] r_p, r_q, r_pend;
    logic        r_have;
    logic        r_ovf;
    logic        r_oval;
    logic [KEPT_W-1:0] r_okept;
    logic        r_ores, r_oovf, r_olast;
    logic        in_acc;
    logic        out_free;
    logic        out_load;
    logic        room;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_oval || !i_out_stall;
    assign room     = r_cnt < CW'(MAX_BOXES);
    assign out_load = out_free && ((r_state == ST_EMIT && r_have) || r_state == ST_FIN);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    o_cmd.load_we     = room;
                    o_cmd.alive_we    = room;
                    o_cmd.alive_wdata = 1'b1;
                    if (i_last_box) n_state = ST_RDI;
                end
            end
            ST_RDI:  n_state = ST_LATI;
            ST_LATI: begin
                o_cmd.latch_si = 1'b1;
                o_cmd.rank_clr = 1'b1;
                n_state        = ST_RDJ;
            end
            ST_RDJ:  n_state = ST_CMPJ;
            ST_CMPJ: begin
                o_cmd.rank_upd = 1'b1;
                o_cmd.j_lt_i   = r_j < r_i;
                if (r_j + CW'(1) == r_cnt) n_state = ST_WRO;
                else n_state = ST_RDJ;
            end
            ST_WRO: begin
                o_cmd.ord_we = 1'b1;
                if (r_i + CW'(1) == r_cnt) n_state = ST_RDA;
                else n_state = ST_RDI;
            end
            ST_RDA:  n_state = (r_a == r_cnt) ? ST_FIN : ST_WTA;
            ST_WTA:  n_state = ST_CHKP;
            ST_CHKP: begin
                if (i_stat.alive && i_stat.score_ok) begin
                    o_cmd.latch_p = 1'b1;
                    n_state       = ST_EMIT;
                end else begin
                    n_state = ST_RDA;
                end
            end
            ST_EMIT: if (!r_have || out_free) n_state = ST_RDB;
            ST_RDB:  n_state = (r_b == r_cnt) ? ST_RDA : ST_WTB;
            ST_WTB:  n_state = ST_CHKQ;
            ST_CHKQ: begin
                if (i_stat.alive) begin
                    o_cmd.start_ov = 1'b1;
                    n_state        = ST_OV;
                end else begin
                    n_state = ST_RDB;
                end
            end
            ST_OV: begin
                if (i_stat.ov_done) begin
                    o_cmd.alive_we    = i_stat.ov_hit;
                    o_cmd.alive_wdata = 1'b0;
                    n_state           = ST_RDB;
                end
            end
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_RDJ:         o_rd_addr = r_j[IW-1:0];
            ST_WTA, ST_WTB: o_rd_addr = i_ord_rdata;
            default:        o_rd_addr = r_i[IW-1:0];
        endcase
    end

    assign o_ord_raddr = (r_state == ST_RDB) ? r_b[IW-1:0] : r_a[IW-1:0];
    assign o_wr_addr   = (r_state == ST_IDLE) ? r_cnt[IW-1:0] : r_q;
    assign o_ord_wdata = r_i[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_have  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= (r_oval && i_out_stall) || out_load;
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (room) r_cnt <= r_cnt + CW'(1);
                        else r_ovf <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (!r_have || out_free) r_have <= 1'b1;
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_have <= 1'b0;
                        r_cnt  <= '0;
                        r_ovf  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_i <= '0;
                r_a <= '0;
            end
            ST_LATI: r_j <= '0;
            ST_CMPJ: r_j <= r_j + CW'(1);
            ST_WRO:  r_i <= r_i + CW'(1);
            ST_WTA:  r_p <= i_ord_rdata;
            ST_CHKP: begin
                if (!(i_stat.alive && i_stat.score_ok)) r_a <= r_a + CW'(1);
            end
            ST_EMIT: begin
                if (!r_have || out_free) begin
                    r_pend <= r_p;
                    r_b    <= r_a + CW'(1);
                    if (r_have) begin
                        r_okept <= KEPT_W'(r_pend);
                        r_ores  <= 1'b1;
                        r_oovf  <= r_ovf;
                        r_olast <= 1'b0;
                    end
                end
            end
            ST_RDB:  if (r_b == r_cnt) r_a <= r_a + CW'(1);
            ST_WTB:  r_q <= i_ord_rdata;
            ST_CHKQ: if (!i_stat.alive) r_b <= r_b + CW'(1);
            ST_OV:   if (i_stat.ov_done) r_b <= r_b + CW'(1);
            ST_FIN: begin
                if (out_free) begin
                    r_okept <= r_have ? KEPT_W'(r_pend) : '0;
                    r_ores  <= r_have;
                    r_oovf  <= r_ovf;
                    r_olast <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall   = r_state != ST_IDLE;
    assign o_out_valid  = r_oval;
    assign o_kept_index = r_okept;
    assign o_valid_res  = r_ores;
    assign o_overflow   = r_oovf;
    assign o_last       = r_olast;
endmodule

[hdl/box_non_max_suppression.sv]
// Greedy non-maximum suppression over a set of boxes, with plain or distance-penalized IoU.
//
// Input channel: one box per transaction (centre, size, score), taken while o_in_stall
// is low and i_in_valid is high. A transaction with i_last_box set closes the set.
// Boxes beyond MAX_BOXES are dropped and flag overflow on every result of the set.
// After the closing box the block stalls its input while it ranks the N stored boxes
// and then walks them in score order. Each pairwise overlap test runs through a
// multiply stage and a shared one-bit-per-cycle divider, with one division in IoU mode
// and a second with the distance penalty; in the worst case the divider dominates.
// Output channel: kept arrival indices in descending score order, last one marked.
// A set with no kept box gives one transaction with o_valid_res low and o_last high.
// A single output register holds each result; while i_out_stall is high the walk
// pauses before the next kept box is reported. The final result may still wait there
// while the next set loads. The user must write configuration through i_cfg_* while idle;
// the block itself does not enforce this. Synchronous reset returns the block to idle
// with an empty set and the default thresholds; the box memories need no clearing.
module box_non_max_suppression import bnms_pkg::*; #(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [FIELD_W-1:0]   i_center_x,
    input  logic [FIELD_W-1:0]   i_center_y,
    input  logic [FIELD_W-1:0]   i_box_width,
    input  logic [FIELD_W-1:0]   i_box_height,
    input  logic [FIELD_W-1:0]   i_box_score,
    input  logic                 i_last_box,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [KEPT_W-1:0]    o_kept_index,
    output logic                 o_valid_res,
    output logic                 o_overflow,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FIELD_W-1:0]   i_cfg_data
);
    localparam int IW = $clog2(MAX_BOXES);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic [IW-1:0] wr_addr, rd_addr, ord_raddr, ord_wdata, ord_rdata;

    bnms_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_last_box   (i_last_box),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kept_index (o_kept_index),
        .o_valid_res  (o_valid_res),
        .o_overflow   (o_overflow),
        .o_last       (o_last),
        .o_cmd        (cmd),
        .o_wr_addr    (wr_addr),
        .o_rd_addr    (rd_addr),
        .o_ord_raddr  (ord_raddr),
        .o_ord_wdata  (ord_wdata),
        .i_stat       (stat),
        .i_ord_rdata  (ord_rdata)
    );

    bnms_datapath #(.MAX_BOXES(MAX_BOXES)) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_wr_addr    (wr_addr),
        .i_rd_addr    (rd_addr),
        .i_ord_raddr  (ord_raddr),
        .i_ord_wdata  (ord_wdata),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .i_box_score  (i_box_score),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_stat       (stat),
        .o_ord_rdata  (ord_rdata)
    );

    // An empty result always closes its set.
    a_empty_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |-> o_last)
        else $error("empty result without last flag");

    // Box memory writes happen only on an accepted input transaction.
    a_load_on_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_we |-> i_in_valid && !o_in_stall)
        else $error("box stored without an accepted transaction");

    // The overlap unit cannot report its result right after a start.
    a_ov_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start_ov |=> !stat.ov_done)
        else $error("overlap result reported too early");
endmodule
